@@ sv/lstm2d_pkg.sv @@
// Shared types, constants and activation functions of the 2-D LSTM cell datapath.
package lstm2d_pkg;

  localparam int DATA_W = 16;   // Q4.12 data width
  localparam int GATE_W = 13;   // gate value, unsigned Q12 in [0, 4096]
  localparam int TANH_W = 14;   // tanh value, signed Q12 in [-4096, 4096]
  localparam int HID_W  = 14;   // hidden output width
  localparam int PROD_W = 30;   // gate times cell value, Q24
  localparam int SUM_W  = 32;   // three products plus rounding offset
  localparam int HPROD_W = 26;  // gate times tanh, Q24
  localparam int HSUM_W = 28;
  localparam int FRAC_W = 12;

  typedef logic [GATE_W-1:0]        gate_t;
  typedef logic signed [TANH_W-1:0] tanh_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    gate_t ig;
    gate_t fg;
    gate_t og;
    gate_t rg;
    tanh_t cg;
  } act_t;

  localparam gate_t Q_ONE     = 13'd4096;
  localparam tanh_t TANH_OFS  = 14'sd4096;
  localparam logic [16:0] SIG_SAT_TH = 17'd20480;  // |x| >= 5.0
  localparam logic [16:0] SIG_MID_TH = 17'd9728;   // |x| >= 2.375
  localparam logic [16:0] SIG_LOW_TH = 17'd4096;   // |x| >= 1.0
  localparam gate_t SIG_MID_OFS = 13'd3456;
  localparam gate_t SIG_LOW_OFS = 13'd2560;
  localparam gate_t SIG_CTR_OFS = 13'd2048;

  localparam logic signed [SUM_W-1:0]  RND_SUM = 32'sd2048;
  localparam logic signed [HSUM_W-1:0] RND_HID = 28'sd2048;
  localparam logic signed [SUM_W-1:0]  CELL_MAX = 32'sd32767;
  localparam logic signed [SUM_W-1:0]  CELL_MIN = -32'sd32768;

  // Piecewise-linear sigmoid on a 17-bit signed Q12 argument.
  function automatic gate_t plan_sigmoid(input logic signed [16:0] x);
    logic [16:0] a;
    gate_t       y;
    a = x[16] ? 17'(-x) : 17'(x);
    if (a >= SIG_SAT_TH) begin
      y = Q_ONE;
    end else if (a >= SIG_MID_TH) begin
      y = gate_t'(a >> 5) + SIG_MID_OFS;
    end else if (a >= SIG_LOW_TH) begin
      y = gate_t'(a >> 3) + SIG_LOW_OFS;
    end else begin
      y = gate_t'(a >> 2) + SIG_CTR_OFS;
    end
    return x[16] ? (Q_ONE - y) : y;
  endfunction

  // tanh(x) = 2*sigmoid(2x) - 1, 2x kept at full width.
  function automatic tanh_t plan_tanh(input data_t x);
    logic signed [16:0] x2;
    gate_t              s;
    x2 = {x, 1'b0};
    s  = plan_sigmoid(x2);
    return tanh_t'({s, 1'b0}) - TANH_OFS;
  endfunction

endpackage

@@ sv/lstm2d_act.sv @@
// Gate activations: four sigmoids, candidate tanh and continuation masking.
module lstm2d_act (
  input  lstm2d_pkg::data_t pre_input_gate,
  input  lstm2d_pkg::data_t pre_forget_gate,
  input  lstm2d_pkg::data_t pre_output_gate,
  input  lstm2d_pkg::data_t pre_candidate,
  input  lstm2d_pkg::data_t pre_row_gate,
  input  logic              keep_left,
  input  logic              keep_above,
  output lstm2d_pkg::act_t  act
);
  import lstm2d_pkg::*;

  always_comb begin
    act.ig = plan_sigmoid(17'(pre_input_gate));
    act.og = plan_sigmoid(17'(pre_output_gate));
    act.cg = plan_tanh(pre_candidate);
    // broken chains drop the predecessor's contribution
    act.fg = keep_left  ? plan_sigmoid(17'(pre_forget_gate)) : '0;
    act.rg = keep_above ? plan_sigmoid(17'(pre_row_gate))    : '0;
  end

endmodule

@@ sv/lstm2d_pkg_unused_guard.sv @@
// Input register stage of the cell: captures activated gates and cell operands.
module lstm2d_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              valid_in,
  input  lstm2d_pkg::act_t  act_in,
  input  lstm2d_pkg::data_t cell_left,
  input  lstm2d_pkg::data_t cell_above,
  output logic              valid_r,
  output lstm2d_pkg::act_t  act_r,
  output lstm2d_pkg::data_t cl_r,
  output lstm2d_pkg::data_t ca_r
);
  import lstm2d_pkg::*;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r <= act_in;
      cl_r  <= cell_left;
      ca_r  <= cell_above;
    end
  end

endmodule

@@ sv/lstm_2d_cell_forward.sv @@
// Top level of the two-dimensional LSTM cell forward datapath.
//
// Pointwise 2-D LSTM cell, one hidden-unit element per transaction. Gate
// pre-activations go through piecewise-linear sigmoid/tanh, the new cell is
// f*cell_left + i*g + r*cell_above rounded half up and saturated to Q4.12, and
// the hidden output is o*tanh(cell). keep_left = 0 zeroes the forget gate,
// keep_above = 0 zeroes the row gate. The datapath is a six-stage pipeline:
// activations, three gate products, sum/round/saturate, tanh of the cell,
// output-gate product, round into the output register. A new transaction can
// be accepted every cycle while in_stall is low; out_valid rises once it has
// passed through every stage into the output register.
// Each stage carries its own valid bit and loads whenever it is empty or the
// next stage can take its contents, so bubbles collapse and a stalled output
// holds while earlier stages keep filling. in_stall rises only when all six
// stages hold transactions and out_stall is high.
module lstm_2d_cell_forward (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  lstm2d_pkg::data_t        in_pre_input_gate,
  input  lstm2d_pkg::data_t        in_pre_forget_gate,
  input  lstm2d_pkg::data_t        in_pre_output_gate,
  input  lstm2d_pkg::data_t        in_pre_candidate,
  input  lstm2d_pkg::data_t        in_pre_row_gate,
  input  lstm2d_pkg::data_t        in_cell_left,
  input  lstm2d_pkg::data_t        in_cell_above,
  input  logic                     in_keep_left,
  input  logic                     in_keep_above,
  output logic                     out_valid,
  input  logic                     out_stall,
  output lstm2d_pkg::data_t        out_cell_out,
  output logic signed [lstm2d_pkg::HID_W-1:0] out_hidden_out
);
  import lstm2d_pkg::*;

  localparam int NSTG = 6;

  // per-stage valid bits, index 0 is the first stage
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:1] vld_r;

  // ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG-2; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // ---- stage 1: activations (registered in the input stage module)
  act_t  act_c;
  act_t  act_r;
  data_t cl_r;
  data_t ca_r;

  lstm2d_act u_act (
    .pre_input_gate  (in_pre_input_gate),
    .pre_forget_gate (in_pre_forget_gate),
    .pre_output_gate (in_pre_output_gate),
    .pre_candidate   (in_pre_candidate),
    .pre_row_gate    (in_pre_row_gate),
    .keep_left       (in_keep_left),
    .keep_above      (in_keep_above),
    .act             (act_c)
  );

  lstm2d_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (rdy[0]),
    .valid_in   (in_valid),
    .act_in     (act_c),
    .cell_left  (in_cell_left),
    .cell_above (in_cell_above),
    .valid_r    (vld[0]),
    .act_r      (act_r),
    .cl_r       (cl_r),
    .ca_r       (ca_r)
  );

  // valid bits of the later stages
  assign vld[NSTG-1:1] = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- stage 2: three gate products, Q24
  logic signed [PROD_W-1:0] pf_r, pi_r, pr_r;
  logic signed [PROD_W-1:0] pf_nxt, pi_nxt, pr_nxt;
  gate_t og2_r;

  always_comb begin
    pf_nxt = PROD_W'($signed({1'b0, act_r.fg})) * PROD_W'(cl_r);
    pi_nxt = PROD_W'($signed({1'b0, act_r.ig})) * PROD_W'(act_r.cg);
    pr_nxt = PROD_W'($signed({1'b0, act_r.rg})) * PROD_W'(ca_r);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      pf_r  <= pf_nxt;
      pi_r  <= pi_nxt;
      pr_r  <= pr_nxt;
      og2_r <= act_r.og;
    end
  end

  // ---- stage 3: exact sum, round half up to Q12, saturate
  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] rnd_c;
  data_t c_nxt;
  data_t c3_r;
  gate_t og3_r;

  always_comb begin
    sum_c = SUM_W'(pf_r) + SUM_W'(pi_r) + SUM_W'(pr_r) + RND_SUM;
    rnd_c = sum_c >>> FRAC_W;   // arithmetic shift is floor
    if (rnd_c > CELL_MAX) begin
      c_nxt = data_t'(CELL_MAX);
    end else if (rnd_c < CELL_MIN) begin
      c_nxt = data_t'(CELL_MIN);
    end else begin
      c_nxt = data_t'(rnd_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      c3_r  <= c_nxt;
      og3_r <= og2_r;
    end
  end

  // ---- stage 4: tanh of the new cell
  tanh_t tc4_r;
  data_t c4_r;
  gate_t og4_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      tc4_r <= plan_tanh(c3_r);
      c4_r  <= c3_r;
      og4_r <= og3_r;
    end
  end

  // ---- stage 5: output gate product, Q24
  logic signed [HPROD_W-1:0] hp5_r;
  logic signed [HPROD_W-1:0] hp_nxt;
  data_t c5_r;

  assign hp_nxt = HPROD_W'($signed({1'b0, og4_r})) * HPROD_W'(tc4_r);

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      hp5_r <= hp_nxt;
      c5_r  <= c4_r;
    end
  end

  // ---- stage 6: round hidden value into the output register
  logic signed [HSUM_W-1:0]  hsum_c;
  logic signed [HID_W-1:0]   hid_nxt;
  data_t                     cell_out_r;
  logic signed [HID_W-1:0]   hid_out_r;

  always_comb begin
    hsum_c  = HSUM_W'(hp5_r) + RND_HID;
    hid_nxt = HID_W'(hsum_c >>> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      cell_out_r <= c5_r;
      hid_out_r  <= hid_nxt;
    end
  end

  assign out_valid      = vld[NSTG-1];
  assign out_cell_out   = cell_out_r;
  assign out_hidden_out = hid_out_r;

  // ---- checks
  // input side can only back up when the whole pipe is full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld))
    else $error("in_stall with an empty pipeline stage");

  // gates stay within [0, 1]
  a_gate_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld[0] |-> (act_r.ig <= Q_ONE && act_r.fg <= Q_ONE &&
                act_r.og <= Q_ONE && act_r.rg <= Q_ONE))
    else $error("gate value out of range");

  // tanh of the cell stays within [-1, 1]
  a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld[3] |-> (tc4_r <= TANH_OFS && tc4_r >= -TANH_OFS))
    else $error("cell tanh out of range");

  // hidden output bounded by one in magnitude
  a_hid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hidden_out <= 14'sd4096 && out_hidden_out >= -14'sd4096))
    else $error("hidden output out of range");

endmodule
